// File: src/distinct_nonzero_count_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the distinct nonzero count block
// Shorthand for clocked implications checked outside reset.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_NONZERO_COUNT_ASSERT_SVH
`define DISTINCT_NONZERO_COUNT_ASSERT_SVH

// Same-cycle implication.
`define DNC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DNC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/dnc_pkg.sv
// ----------------------------------------------------------------------------
// dnc_pkg
// Sizes, types and state codes shared by the distinct nonzero count block.
// ----------------------------------------------------------------------------
package dnc_pkg;

  localparam int unsigned MAX_DISTINCT    = 64;
  localparam int unsigned LEVEL_WIDTH     = 16;
  localparam int unsigned IN_WIDTH        = 16;
  localparam int unsigned COUNT_OUT_WIDTH = 7;
  localparam int unsigned STORE_WIDTH     = (LEVEL_WIDTH < IN_WIDTH) ? LEVEL_WIDTH : IN_WIDTH;
  localparam int unsigned COUNT_WIDTH     = $clog2(MAX_DISTINCT + 1);

  typedef logic [STORE_WIDTH-1:0] level_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic hit;
    logic claim;
  } cell_stat_t;

  typedef struct packed {
    logic hit;
    logic claim;
    logic full;
  } chain_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_e;

endpackage

// File: src/dnc_cell.sv
// ----------------------------------------------------------------------------
// dnc_cell
// One storage cell: holds a value and its valid bit, checks the probe when
// the token arrives and either reports a hit, claims itself, or passes on.
// ----------------------------------------------------------------------------
module dnc_cell import dnc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clear_i,
  input  level_t     probe_i,
  input  logic       token_i,
  output logic       token_o,
  output cell_stat_t stat_o
);

  logic   token_q, token_d;
  logic   valid_q, valid_d;
  level_t value_q;
  logic   match;

  assign match        = valid_q && (value_q == probe_i);
  assign stat_o.hit   = token_q && match;
  assign stat_o.claim = token_q && !valid_q;
  assign token_o      = token_q && valid_q && !match;
  assign token_d      = token_i;

  always_comb begin
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (stat_o.claim) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      token_q <= token_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat_o.claim) begin
      value_q <= probe_i;
    end
  end

endmodule

// File: src/dnc_chain.sv
// ----------------------------------------------------------------------------
// dnc_chain
// Row of storage cells linked by the search token. Collects the cell
// responses and flags a token that walked off the end of a full row.
// ----------------------------------------------------------------------------
module dnc_chain import dnc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clear_i,
  input  logic        start_i,
  input  level_t      probe_i,
  output chain_stat_t stat_o
);

  logic [MAX_DISTINCT:0]   token;
  logic [MAX_DISTINCT-1:0] hit;
  logic [MAX_DISTINCT-1:0] claim;

  assign token[0] = start_i;

  for (genvar i = 0; i < MAX_DISTINCT; i++) begin : g_cell
    cell_stat_t cstat;

    dnc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (clear_i),
      .probe_i (probe_i),
      .token_i (token[i]),
      .token_o (token[i+1]),
      .stat_o  (cstat)
    );

    assign hit[i]   = cstat.hit;
    assign claim[i] = cstat.claim;
  end

  assign stat_o.hit   = |hit;
  assign stat_o.claim = |claim;
  assign stat_o.full  = token[MAX_DISTINCT];

endmodule

// File: src/distinct_nonzero_count.sv
// ----------------------------------------------------------------------------
// distinct_nonzero_count
// Counts the distinct nonzero values of a group, one value per transfer.
// ----------------------------------------------------------------------------
// Timing: a zero value is taken without a search; a nonzero value is held
// while the token walks to the matching or first free cell, or off the end
// of a full store. The last value of a group then loads the result register,
// waiting while an earlier result is still held.
// Throughput is one value per search, the token walking one cell a cycle.
// Reset is asynchronous and active low and empties the store at once.
// ----------------------------------------------------------------------------
module distinct_nonzero_count import dnc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [IN_WIDTH-1:0]        level_i,
  input  logic                       last_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  output logic [COUNT_OUT_WIDTH-1:0] distinct_count_o,
  output logic                       overflow_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i
);

`include "distinct_nonzero_count_assert.svh"

  // The store is a row of cells. Each new value is held in probe_q while a
  // token enters the first cell and moves one cell per cycle. Valid cells
  // fill from the front, so the token either meets the value, reaches the
  // first free cell and stores it there, or drops off a full row.

  state_e      state_q, state_d;
  level_t      probe_q;
  level_t      level_in;
  logic        last_q;
  count_t      count_q, count_d;
  logic        ovf_q, ovf_d;
  chain_stat_t stat;

  logic        accept;
  logic        start;
  logic        emit;
  logic        slot_free;
  logic        done;

  // Result register: the next group can start while a result waits.
  logic                       out_valid_q, out_valid_d;
  logic [COUNT_OUT_WIDTH-1:0] out_count_q;
  logic                       out_ovf_q;

  assign level_in  = level_i[STORE_WIDTH-1:0];
  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign done      = stat.hit || stat.claim || stat.full;

  dnc_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (emit),
    .start_i (start),
    .probe_i (probe_q),
    .stat_o  (stat)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (level_in != '0) begin
            state_d = ST_SEARCH;
          end else if (last_i) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SEARCH: begin
        if (done) begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o = 1'b0;
    start      = 1'b0;
    emit       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        start      = in_valid_i && (level_in != '0);
      end
      ST_SEARCH: begin
      end
      ST_EMIT: begin
        emit = slot_free;
      end
      default: begin
      end
    endcase
  end

  // Group counters: the group is cleared when its result is loaded.
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (emit) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (state_q == ST_SEARCH) begin
      if (stat.claim) begin
        count_d = count_q + count_t'(1);
      end
      if (stat.full) begin
        ovf_d = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      probe_q <= level_in;
      last_q  <= last_i;
    end
    if (emit) begin
      out_count_q <= COUNT_OUT_WIDTH'(count_q);
      out_ovf_q   <= ovf_q;
    end
  end

  assign distinct_count_o = out_count_q;
  assign overflow_o       = out_ovf_q;
  assign out_valid_o      = out_valid_q;

  // Loading a result leaves the group counters empty.
  `DNC_ASSERT_NEXT(a_emit_clears, emit, (count_q == '0) && !ovf_q, "group not cleared")
  // A claimed cell adds exactly one to the count.
  `DNC_ASSERT_NEXT(a_claim_counts, (state_q == ST_SEARCH) && stat.claim,
                   count_q == count_t'($past(count_q) + count_t'(1)), "claim not counted")
  // Overflow can only be flagged once every cell is in use.
  `DNC_ASSERT_NOW(a_ovf_full, ovf_q, count_q == count_t'(MAX_DISTINCT), "overflow early")

endmodule

// File: test/tb_distinct_nonzero_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distinct_nonzero_count
// Drives groups of levels into the distinct nonzero counter and checks every
// emitted count and overflow flag against a queue-based prediction.
// ----------------------------------------------------------------------------
module tb_distinct_nonzero_count;
  import dnc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned ITEM_TARGET = 1750;
  localparam int unsigned MAX_REPORTS = 10;

  typedef logic [IN_WIDTH-1:0] level_in_t;

  // One group result as the block presents it.
  typedef struct packed {
    logic [COUNT_OUT_WIDTH-1:0] count;
    logic                       overflow;
  } group_result_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  level_in_t                  level_i     = '0;
  logic                       last_i      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  logic [COUNT_OUT_WIDTH-1:0] distinct_count_o;
  logic                       overflow_o;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;

  // Random idling on both sides; cleared for one long quiet stretch.
  bit            idle_on      = 1'b1;
  // Cycles the receiver still has to hold off; counted down by the receiver.
  int            rx_hold_left = 0;
  int unsigned   items_sent   = 0;
  int unsigned   mismatches   = 0;
  int unsigned   cycle_count  = 0;

  // Prediction state: the distinct levels of the open group, in arrival
  // order, whether a new level was dropped because the store was full, and
  // the group results still owed by the block.
  level_t        seen_levels[$];
  logic          store_overflowed = 1'b0;
  group_result_t group_results_q[$];

  distinct_nonzero_count dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .level_i          (level_i),
    .last_i           (last_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .distinct_count_o (distinct_count_o),
    .overflow_o       (overflow_o),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i)
  );

  always #5 clk_i = ~clk_i;

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL distinct_nonzero_count");
      $finish;
    end
  end

  // Fold one accepted level into the open group. Only the low LEVEL_WIDTH
  // bits matter, zeros are skipped, and a new level that finds the store full
  // is dropped while the overflow flag is raised. The last level of a group
  // is counted before the result is formed, and the group is then closed.
  function automatic void absorb_level(input level_in_t raw, input logic is_last);
    level_t        lv;
    bit            hit;
    group_result_t res;
    lv  = level_t'(raw);
    hit = 1'b0;
    foreach (seen_levels[i]) begin
      if (seen_levels[i] == lv) hit = 1'b1;
    end
    if (lv != '0 && !hit) begin
      if (seen_levels.size() < MAX_DISTINCT) begin
        seen_levels.push_back(lv);
      end else begin
        store_overflowed = 1'b1;
      end
    end
    if (is_last) begin
      res.count    = COUNT_OUT_WIDTH'(seen_levels.size());
      res.overflow = store_overflowed;
      group_results_q.push_back(res);
      seen_levels.delete();
      store_overflowed = 1'b0;
    end
  endfunction

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    end
  endfunction

  // Appends n nonzero levels that are not yet in q.
  function automatic void fill_distinct(ref level_in_t q[$], input int n);
    level_in_t cand;
    bit        dup;
    repeat (n) begin
      do begin
        cand = level_in_t'($urandom_range(1, 16'hFFFF));
        dup  = 1'b0;
        foreach (q[i]) begin
          if (q[i] == cand) dup = 1'b1;
        end
      end while (dup);
      q.push_back(cand);
    end
  endfunction

  // Result checker. Outputs are sampled at the edge, before the block's
  // registers update, so the values seen are the ones of the transfer.
  always @(posedge clk_i) begin
    group_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (group_results_q.size() == 0) begin
        flag_mismatch("result with no group pending", 'x, 32'(distinct_count_o));
      end else begin
        want = group_results_q.pop_front();
        if (distinct_count_o !== want.count) begin
          flag_mismatch("distinct_count", 32'(want.count), 32'(distinct_count_o));
        end
        if (overflow_o !== want.overflow) begin
          flag_mismatch("overflow", 32'(want.overflow), 32'(overflow_o));
        end
      end
    end
  end

  // Receiver: a requested hold-off takes priority over the random stalls.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_left--;
      end else if (idle_on && $urandom_range(99) < 6) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offers one level and returns at the edge of its transfer. Valid is left
  // high so that a following level goes out back to back; whoever stops
  // sending lowers it in the same step.
  task automatic send_level(input level_in_t lv, input logic is_last);
    while (idle_on && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    level_i    <= lv;
    last_i     <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_level(lv, is_last);
    items_sent++;
  endtask

  task automatic send_group(input level_in_t grp[$]);
    foreach (grp[i]) send_level(grp[i], i == grp.size() - 1);
  endtask

  // Stops offering and waits until every owed result has been taken.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (group_results_q.size() != 0);
  endtask

  // Field extremes, duplicates, zeros inside and at the end of a group, and
  // a new level arriving on the last transfer.
  task automatic test_directed();
    send_level(16'h0000, 1'b1);
    send_level(16'hFFFF, 1'b1);
    send_level(16'h0001, 1'b0);
    send_level(16'h0000, 1'b0);
    send_level(16'h0001, 1'b0);
    send_level(16'h8000, 1'b1);
    send_level(16'h5555, 1'b0);
    send_level(16'hAAAA, 1'b0);
    send_level(16'h5555, 1'b0);
    send_level(16'h0000, 1'b1);
    send_level(16'h0000, 1'b0);
    send_level(16'h0000, 1'b0);
    send_level(16'h0000, 1'b1);
    send_level(16'h0007, 1'b0);
    send_level(16'h0007, 1'b0);
    send_level(16'h0009, 1'b1);
    send_level(16'hFFFE, 1'b0);
    send_level(16'h7FFF, 1'b1);
  endtask

  // Groups around the store size: exactly full, one too many on the last
  // transfer, overflow in mid group followed by stored repeats and a zero,
  // and a short group after that to show the store was emptied.
  task automatic test_store_full();
    level_in_t grp[$];
    fill_distinct(grp, MAX_DISTINCT);
    grp.push_back(grp[0]);
    grp.push_back(grp[MAX_DISTINCT-1]);
    send_group(grp);
    grp.delete();
    fill_distinct(grp, MAX_DISTINCT + 1);
    send_group(grp);
    grp.delete();
    fill_distinct(grp, MAX_DISTINCT + 6);
    grp.push_back(grp[3]);
    grp.push_back(16'h0000);
    send_group(grp);
    grp.delete();
    grp.push_back(16'h0042);
    grp.push_back(16'h0042);
    send_group(grp);
  endtask

  // The receiver holds off for a long stretch while short groups keep coming,
  // so the block has to stall its input; then the sender waits it out.
  task automatic test_backpressure();
    level_in_t grp[$];
    rx_hold_left = 400;
    repeat (8) begin
      grp.delete();
      fill_distinct(grp, $urandom_range(1, 4));
      send_group(grp);
    end
    wait_results_drained();
  endtask

  // Random groups. Most are short; some are medium; a few run past the store
  // size. Contents come from full-range values, a small per-group pool (many
  // repeats) or small values, with zeros sprinkled in.
  task automatic test_random_groups();
    level_in_t   grp[$];
    level_in_t   pool[$];
    int          len;
    int          mode;
    int unsigned quiet_from;
    int unsigned quiet_to;
    quiet_from = items_sent + 300;
    quiet_to   = quiet_from + 400;
    while (items_sent < ITEM_TARGET) begin
      idle_on = !(items_sent >= quiet_from && items_sent < quiet_to);
      grp.delete();
      pool.delete();
      case ($urandom_range(19))
        0: begin
          fill_distinct(grp, $urandom_range(MAX_DISTINCT + 1, MAX_DISTINCT + 26));
        end
        1, 2, 3: len = $urandom_range(13, 40);
        default: len = $urandom_range(1, 12);
      endcase
      if (grp.size() == 0) begin
        mode = $urandom_range(2);
        fill_distinct(pool, $urandom_range(1, 8));
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 15) begin
            grp.push_back(16'h0000);
          end else begin
            case (mode)
              0: grp.push_back(level_in_t'($urandom_range(0, 16'hFFFF)));
              1: grp.push_back(pool[$urandom_range(pool.size() - 1)]);
              default: grp.push_back(level_in_t'($urandom_range(1, 15)));
            endcase
          end
        end
      end
      send_group(grp);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    // Sender pause: nothing goes out until every owed result is back.
    wait_results_drained();
    test_store_full();
    test_backpressure();
    test_random_groups();
    wait_results_drained();
    // Let a late or spurious result show up before deciding.
    repeat (MAX_DISTINCT + 4) @(posedge clk_i);
    if (mismatches == 0 && group_results_q.size() == 0) begin
      $display("PASS distinct_nonzero_count");
    end else begin
      $display("FAIL distinct_nonzero_count");
    end
    $finish;
  end

endmodule
